/* hdl/gble_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer line editor package
// Types, sizes and command codes shared by the editor RTL.
// ----------------------------------------------------------------------------
package gble_pkg;

   localparam int BUF_SIZE = 4096;
   localparam int ADDR_W   = $clog2(BUF_SIZE);
   localparam int POS_W    = ADDR_W + 1;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_DELCH  = 3'd2;
   localparam logic [2:0] OP_DELRNG = 3'd3;
   localparam logic [2:0] OP_LINELEN = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;
   localparam logic [2:0] OP_SAVED  = 3'd6;

   localparam logic [7:0] NEWLINE = 8'd10;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [12:0] line_a;
      logic [12:0] pos_a;
      logic [12:0] line_b;
      logic [12:0] pos_b;
      logic [7:0]  char_in;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [12:0] value;
      logic [12:0] line_total;
      logic        changed;
   } rsp_type;

endpackage

/* hdl/gap_buffer_line_editor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer line editor
// Line-addressed text store held as a gap buffer in one byte memory, run by a
// small sequencer around one memory read port and one write port.
// ----------------------------------------------------------------------------
// Clear, mark saved, unused opcodes and lines out of range go straight to the result; others
// walk the text byte by byte in the line and line end searches (done twice for a range
// delete) and shift one byte at a time across the gap when it moves.
// Throughput: one command at a time; a new command is taken once the previous
// result is handed to the output register. The memory port sets the pace.
// Reset: synchronous; the text is empty with one line and no change pending.
module gap_buffer_line_editor_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gble_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gble_pkg::rsp_type rsp_data
);
   import gble_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FSET   = 4'd1;
   localparam logic [3:0] S_FIND   = 4'd2;
   localparam logic [3:0] S_FCHK   = 4'd3;
   localparam logic [3:0] S_STOP   = 4'd4;
   localparam logic [3:0] S_SCHK   = 4'd5;
   localparam logic [3:0] S_DECIDE = 4'd6;
   localparam logic [3:0] S_RDB    = 4'd7;
   localparam logic [3:0] S_RDW    = 4'd8;
   localparam logic [3:0] S_MOVE   = 4'd9;
   localparam logic [3:0] S_MVWR   = 4'd10;
   localparam logic [3:0] S_EDIT   = 4'd11;
   localparam logic [3:0] S_DONE   = 4'd12;

   localparam logic [POS_W-1:0] BUF_END = POS_W'(BUF_SIZE);

   logic [3:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [12:0]      fl_ff, fl_in, fp_ff, fp_in, tl_ff, tl_in, tp_ff, tp_in;
   logic [7:0]       ch_ff, ch_in;
   logic             phase_ff, phase_in;
   logic             left_ff, left_in;
   logic [POS_W-1:0] p_ff, p_in, s_ff, s_in, e_ff, e_in;
   logic [12:0]      n_ff, n_in;
   logic [POS_W-1:0] fs_ff, fs_in, fspan_ff, fspan_in;
   logic [POS_W-1:0] pos_ff, pos_in, del_ff, del_in;
   logic             ok_ff, ok_in;
   logic [12:0]      value_ff, value_in;
   logic [POS_W-1:0] gs_ff, gs_in, ge_ff, ge_in;
   logic [12:0]      lines_ff, lines_in;
   logic             changed_ff, changed_in;
   logic [POS_W-1:0] cls_ff, cls_in;
   logic [12:0]      cln_ff, cln_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [7:0]        mem [BUF_SIZE];
   logic [7:0]        rd_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic              re, we;
   logic [7:0]        wdata;

   logic [POS_W-1:0] gap_len, text_len, span, cur_len, phys_idx, phys_p, phys_pos;
   logic [12:0]      tgt;
   logic             swap;

   assign gap_len  = ge_ff - gs_ff;
   assign text_len = BUF_END - gap_len;
   assign cur_len  = e_ff - s_ff;
   assign span     = cur_len + ((e_ff < text_len) ? POS_W'(1) : POS_W'(0));
   assign tgt      = phase_ff ? tl_ff : fl_ff;
   assign phys_p   = (p_ff < gs_ff) ? p_ff : p_ff + gap_len;
   assign phys_pos = (pos_ff < gs_ff) ? pos_ff : pos_ff + gap_len;
   assign phys_idx = (state_ff == S_RDB) ? phys_pos : phys_p;
   assign swap     = (req_data.line_b < req_data.line_a) ||
                     ((req_data.line_b == req_data.line_a) &&
                      (req_data.pos_b < req_data.pos_a));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;   op_in = op_ff;       fl_in = fl_ff;   fp_in = fp_ff;
      tl_in = tl_ff;         tp_in = tp_ff;       ch_in = ch_ff;   phase_in = phase_ff;
      left_in = left_ff;     p_in = p_ff;         s_in = s_ff;     e_in = e_ff;
      n_in = n_ff;           fs_in = fs_ff;       fspan_in = fspan_ff;
      pos_in = pos_ff;       del_in = del_ff;     ok_in = ok_ff;   value_in = value_ff;
      gs_in = gs_ff;         ge_in = ge_ff;       lines_in = lines_ff;
      changed_in = changed_ff; cls_in = cls_ff;   cln_in = cln_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      re = 1'b0;  we = 1'b0;
      raddr = phys_idx[ADDR_W-1:0];
      waddr = gs_ff[ADDR_W-1:0];
      wdata = rd_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.opcode;
               ch_in = req_data.char_in;
               phase_in = 1'b0;
               ok_in = 1'b0;
               value_in = '0;
               if (req_data.opcode == OP_DELRNG && swap) begin
                  fl_in = req_data.line_b;  fp_in = req_data.pos_b;
                  tl_in = req_data.line_a;  tp_in = req_data.pos_a;
               end else begin
                  fl_in = req_data.line_a;  fp_in = req_data.pos_a;
                  tl_in = req_data.line_b;  tp_in = req_data.pos_b;
               end
               state_in = S_DONE;
               case (req_data.opcode)
                  OP_CLEAR: begin
                     gs_in = '0;  ge_in = BUF_END;  lines_in = 13'd1;
                     changed_in = 1'b0;  cls_in = '0;  cln_in = '0;
                     ok_in = 1'b1;
                  end
                  OP_SAVED: begin
                     changed_in = 1'b0;
                     ok_in = 1'b1;
                  end
                  OP_INSERT, OP_DELCH, OP_LINELEN, OP_READ: begin
                     if (req_data.line_a < lines_ff) state_in = S_FSET;
                  end
                  OP_DELRNG: begin
                     if (req_data.line_a < lines_ff && req_data.line_b < lines_ff)
                        state_in = S_FSET;
                  end
                  default: ;
               endcase
            end
         end
         S_FSET: begin
            // The cached line start is a shortcut only when it lies at or
            // before the wanted line.
            if (cln_ff <= tgt && cls_ff <= text_len) begin
               p_in = cls_ff;  n_in = cln_ff;
            end else begin
               p_in = '0;  n_in = '0;
            end
            state_in = S_FIND;
         end
         S_FIND: begin
            if (n_ff < tgt && p_ff < text_len) begin
               re = 1'b1;
               state_in = S_FCHK;
            end else begin
               cls_in = p_ff;  cln_in = n_ff;  s_in = p_ff;
               state_in = S_STOP;
            end
         end
         S_FCHK: begin
            if (rd_ff == NEWLINE) n_in = n_ff + 13'd1;
            p_in = p_ff + POS_W'(1);
            state_in = S_FIND;
         end
         S_STOP: begin
            if (p_ff < text_len) begin
               re = 1'b1;
               state_in = S_SCHK;
            end else begin
               e_in = p_ff;
               state_in = S_DECIDE;
            end
         end
         S_SCHK: begin
            if (rd_ff == NEWLINE) begin
               e_in = p_ff;
               state_in = S_DECIDE;
            end else begin
               p_in = p_ff + POS_W'(1);
               state_in = S_STOP;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (gs_ff != ge_ff) begin
                     pos_in = s_ff + ((fp_ff < cur_len) ? fp_ff : cur_len);
                     state_in = S_MOVE;
                  end
               end
               OP_DELCH, OP_READ: begin
                  if (fp_ff < span) begin
                     pos_in = s_ff + fp_ff;
                     state_in = S_RDB;
                  end
               end
               OP_DELRNG: begin
                  if (!phase_ff) begin
                     fs_in = s_ff;  fspan_in = span;  phase_in = 1'b1;
                     state_in = S_FSET;
                  end else if (fp_ff < fspan_ff && tp_ff <= cur_len) begin
                     pos_in = fs_ff + fp_ff;
                     del_in = (s_ff + tp_ff) - (fs_ff + fp_ff);
                     state_in = S_MOVE;
                  end
               end
               OP_LINELEN: begin
                  value_in = cur_len;
                  ok_in = 1'b1;
               end
               default: ;
            endcase
         end
         S_RDB: begin
            re = 1'b1;
            state_in = S_RDW;
         end
         S_RDW: begin
            if (op_ff == OP_READ) begin
               value_in = {5'd0, rd_ff};
               ok_in = 1'b1;
               state_in = S_DONE;
            end else begin
               ch_in = rd_ff;
               del_in = POS_W'(1);
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            // Each byte shift is a read followed by a write across the gap.
            if (gs_ff > pos_ff && gs_ff != '0) begin
               re = 1'b1;
               raddr = ADDR_W'(gs_ff - POS_W'(1));
               left_in = 1'b1;
               state_in = S_MVWR;
            end else if (gs_ff < pos_ff && ge_ff < BUF_END) begin
               re = 1'b1;
               raddr = ge_ff[ADDR_W-1:0];
               left_in = 1'b0;
               state_in = S_MVWR;
            end else begin
               state_in = S_EDIT;
            end
         end
         S_MVWR: begin
            we = 1'b1;
            if (left_ff) begin
               waddr = ADDR_W'(ge_ff - POS_W'(1));
               gs_in = gs_ff - POS_W'(1);
               ge_in = ge_ff - POS_W'(1);
            end else begin
               waddr = gs_ff[ADDR_W-1:0];
               gs_in = gs_ff + POS_W'(1);
               ge_in = ge_ff + POS_W'(1);
            end
            state_in = S_MOVE;
         end
         S_EDIT: begin
            case (op_ff)
               OP_INSERT: begin
                  we = 1'b1;
                  wdata = ch_ff;
                  gs_in = gs_ff + POS_W'(1);
                  if (ch_ff == NEWLINE) lines_in = lines_ff + 13'd1;
               end
               OP_DELCH: begin
                  ge_in = ge_ff + del_ff;
                  if (ch_ff == NEWLINE) lines_in = lines_ff - 13'd1;
               end
               default: begin
                  ge_in = ge_ff + del_ff;
                  lines_in = lines_ff - (tl_ff - fl_ff);
               end
            endcase
            changed_in = 1'b1;
            cls_in = '0;  cln_in = '0;
            ok_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.ok = ok_ff;
               rsp_data_in.value = value_ff;
               rsp_data_in.line_total = lines_ff;
               rsp_data_in.changed = changed_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;       fl_ff <= fl_in;     fp_ff <= fp_in;
      tl_ff <= tl_in;       tp_ff <= tp_in;     ch_ff <= ch_in;
      left_ff <= left_in;   p_ff <= p_in;       s_ff <= s_in;
      e_ff <= e_in;         n_ff <= n_in;       fs_ff <= fs_in;
      fspan_ff <= fspan_in; pos_ff <= pos_in;   del_ff <= del_in;
      ok_ff <= ok_in;       value_ff <= value_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         gs_ff <= '0;
         ge_ff <= BUF_END;
         lines_ff <= 13'd1;
         changed_ff <= 1'b0;
         cls_ff <= '0;
         cln_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         gs_ff <= gs_in;
         ge_ff <= ge_in;
         lines_ff <= lines_in;
         changed_ff <= changed_in;
         cls_ff <= cls_in;
         cln_ff <= cln_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* verif/gap_buffer_line_editor_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer line editor testbench
// Drives edit commands through the request channel and checks every response
// against an in-bench gap buffer model with line tracking and change flag.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_unit_tb;
   import gble_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Predictor state: plain text array instead of a gap.
   byte unsigned doc_text[$];
   int           doc_lines;
   bit           doc_changed;
   rsp_type      pending_rsp[$];

   int  mismatch_count = 0;
   int  sent_count;
   int  checked_count = 0;
   int  idle_cycles = 0;
   bit  req_gaps_on;
   bit  rsp_gaps_on;
   int  hold_off_cycles;
   int  hold_len = 0;
   int  hold_seq = 0;
   int  hold_seen;

   gap_buffer_line_editor_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Start index of a line in the flat text.
   function automatic int line_start(int line);
      int p;
      int n;
      p = 0;
      n = 0;
      while (n < line && p < doc_text.size()) begin
         if (doc_text[p] == NEWLINE) n++;
         p++;
      end
      return p;
   endfunction

   function automatic int line_end(int start);
      int p;
      p = start;
      while (p < doc_text.size() && doc_text[p] != NEWLINE) p++;
      return p;
   endfunction

   function automatic rsp_type edit_predict(req_type cmd);
      rsp_type r;
      int s, e, span, p, la, pa, lb, pb, fs, fspan, ts, te, t;
      r = '0;
      la = int'(cmd.line_a);
      pa = int'(cmd.pos_a);
      lb = int'(cmd.line_b);
      pb = int'(cmd.pos_b);
      if (cmd.opcode == OP_CLEAR) begin
         doc_text.delete();
         doc_lines = 1;
         doc_changed = 0;
         r.ok = 1'b1;
      end else if (cmd.opcode == OP_SAVED) begin
         doc_changed = 0;
         r.ok = 1'b1;
      end else if (cmd.opcode inside {[OP_INSERT:OP_READ]} && la < doc_lines) begin
         s = line_start(la);
         e = line_end(s);
         span = (e - s) + ((e < doc_text.size()) ? 1 : 0);
         case (cmd.opcode)
            OP_INSERT: begin
               if (doc_text.size() < BUF_SIZE) begin
                  p = (pa < e - s) ? pa : e - s;
                  doc_text.insert(s + p, cmd.char_in);
                  if (cmd.char_in == NEWLINE) doc_lines++;
                  doc_changed = 1;
                  r.ok = 1'b1;
               end
            end
            OP_DELCH: begin
               if (pa < span) begin
                  if (doc_text[s + pa] == NEWLINE) doc_lines--;
                  doc_text.delete(s + pa);
                  doc_changed = 1;
                  r.ok = 1'b1;
               end
            end
            OP_DELRNG: begin
               if (lb < doc_lines) begin
                  if (lb < la || (lb == la && pb < pa)) begin
                     t = la; la = lb; lb = t;
                     t = pa; pa = pb; pb = t;
                  end
                  fs = line_start(la);
                  fe_blk : begin
                     int fe;
                     fe = line_end(fs);
                     fspan = (fe - fs) + ((fe < doc_text.size()) ? 1 : 0);
                  end
                  ts = line_start(lb);
                  te = line_end(ts);
                  if (pa < fspan && pb <= te - ts) begin
                     for (int i = fs + pa; i < ts + pb; i++) doc_text.delete(fs + pa);
                     doc_lines -= lb - la;
                     doc_changed = 1;
                     r.ok = 1'b1;
                  end
               end
            end
            OP_LINELEN: begin
               r.value = 13'(e - s);
               r.ok = 1'b1;
            end
            default: begin
               if (pa < span) begin
                  r.value = {5'd0, doc_text[s + pa]};
                  r.ok = 1'b1;
               end
            end
         endcase
      end
      r.line_total = 13'(doc_lines);
      r.changed = doc_changed;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0d expected %0d",
               checked_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_command(req_type cmd);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(edit_predict(cmd));
      sent_count++;
   endtask

   task automatic finish_burst();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_cmd(logic [2:0] op, int la, int pa, int lb, int pb,
                                        int ch);
      req_type c;
      c.opcode = op;
      c.line_a = 13'(la);
      c.pos_a = 13'(pa);
      c.line_b = 13'(lb);
      c.pos_b = 13'(pb);
      c.char_in = 8'(ch);
      return c;
   endfunction

   // Small line and position values keep hits inside the text.
   function automatic int pick_coord(int hi);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 8191);
         1: return 8191;
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   function automatic req_type random_cmd();
      req_type c;
      int w;
      c = '0;
      w = $urandom_range(0, 99);
      if (w < 40) c.opcode = OP_INSERT;
      else if (w < 50) c.opcode = OP_DELCH;
      else if (w < 56) c.opcode = OP_DELRNG;
      else if (w < 68) c.opcode = OP_LINELEN;
      else if (w < 90) c.opcode = OP_READ;
      else if (w < 93) c.opcode = OP_SAVED;
      else if (w < 95) c.opcode = OP_CLEAR;
      else c.opcode = OP_UNUSED;
      c.line_a = 13'(pick_coord(doc_lines));
      c.pos_a = 13'(pick_coord(12));
      c.line_b = 13'(pick_coord(doc_lines));
      c.pos_b = 13'(pick_coord(12));
      c.char_in = ($urandom_range(0, 3) == 0) ? NEWLINE : 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic test_directed();
      send_command(make_cmd(OP_LINELEN, 0, 0, 0, 0, 0));
      send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0));
      send_command(make_cmd(OP_DELCH, 0, 0, 0, 0, 0));
      send_command(make_cmd(OP_INSERT, 1, 0, 0, 0, 65));
      send_command(make_cmd(OP_INSERT, 0, 8191, 0, 0, 8'hFF));
      send_command(make_cmd(OP_INSERT, 0, 0, 0, 0, 8'h00));
      send_command(make_cmd(OP_INSERT, 0, 1, 0, 0, NEWLINE));
      send_command(make_cmd(OP_INSERT, 1, 0, 0, 0, 8'h5A));
      send_command(make_cmd(OP_READ, 0, 1, 0, 0, 0));
      send_command(make_cmd(OP_READ, 0, 2, 0, 0, 0));
      send_command(make_cmd(OP_LINELEN, 8191, 0, 0, 0, 0));
      send_command(make_cmd(OP_SAVED, 0, 0, 0, 0, 0));
      send_command(make_cmd(OP_UNUSED, 8191, 8191, 8191, 8191, 8'hFF));
      send_command(make_cmd(OP_DELRNG, 1, 1, 0, 1, 0));
      send_command(make_cmd(OP_DELRNG, 0, 0, 0, 0, 0));
      send_command(make_cmd(OP_DELRNG, 0, 5, 0, 6, 0));
      send_command(make_cmd(OP_DELRNG, 0, 0, 8191, 0, 0));
      send_command(make_cmd(OP_DELCH, 0, 8191, 0, 0, 0));
      send_command(make_cmd(OP_READ, 0, 8191, 0, 0, 0));
      send_command(make_cmd(OP_DELCH, 0, 0, 0, 0, 0));
      send_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
      finish_burst();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_command(random_cmd());
         if (i % 60 == 59) finish_burst();
      end
      finish_burst();
   endtask

   // Receiver holds off while commands keep coming, then drains.
   task automatic test_backpressure();
      hold_len = 400;
      hold_seq++;
      for (int i = 0; i < 10; i++) send_command(random_cmd());
      finish_burst();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= 0;
         hold_seen <= 0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_off_cycles <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_gaps_on && !rsp_stall && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_data.ok !== want.ok)
               report_mismatch("ok", int'(rsp_data.ok), int'(want.ok));
            if (rsp_data.value !== want.value)
               report_mismatch("value", int'(rsp_data.value), int'(want.value));
            if (rsp_data.line_total !== want.line_total)
               report_mismatch("line_total", int'(rsp_data.line_total),
                               int'(want.line_total));
            if (rsp_data.changed !== want.changed)
               report_mismatch("changed", int'(rsp_data.changed), int'(want.changed));
         end
         checked_count++;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sent_count = 0;
      doc_lines = 1;
      doc_changed = 0;
      req_gaps_on = 1;
      rsp_gaps_on = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(700);
      req_gaps_on = 0;
      rsp_gaps_on = 0;
      test_random(100);
      repeat (20) @(posedge clock);
      $display("Ran %0d commands, %0d responses checked: inserts, char and range deletes,",
               sent_count, checked_count);
      $display("line queries, reads, rejected commands and a long receiver hold-off.");
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
